// File: hw/rtl/wwrc_pkg.sv
// ----------------------------------------------------------------------------
// wwrc_pkg: shared constants for the windowed weighted RMS comfort meter
// Field widths, derived datapath widths and configuration register indexes.
// ----------------------------------------------------------------------------
package wwrc_pkg;

    // Sample format and window limits
    localparam int SAMPLE_BITS = 16;
    localparam int MAX_WINDOW  = 64;
    localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
    localparam int LEN_W       = 7;
    localparam int WEIGHT_W    = 16;
    localparam int OUT_W       = 16;
    localparam int WIN_W       = 32;
    localparam int CT_W        = 48;
    localparam int NLANE       = 4;

    // Digit-serial squaring and weighting: 4-bit digits
    localparam int DIG_LOG     = 2;
    localparam int DIG_W       = 1 << DIG_LOG;
    localparam int N_DIG       = SAMPLE_BITS / DIG_W;
    localparam int DIGC_W      = $clog2(N_DIG);

    // Sums of squares (Q16.16) and the weighted total (Q16.32)
    localparam int SUM_W       = 37;
    localparam int PAIR_W      = SUM_W + 1;
    localparam int TOT_W       = PAIR_W + WEIGHT_W + 1;

    // Shared divider: dividend wide enough for the weighted total
    localparam int DIV_W       = TOT_W;
    localparam int DVS_W       = WIN_W;

    // Square root: radicand padded to an even width
    localparam int ROOT_W      = (DIV_W + 1) / 2;
    localparam int RAD_W       = 2 * ROOT_W;
    localparam int RND_SH      = 8;

    // Configuration port
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTION_WEIGHT = 2'd2;

    // Reset values of the configuration registers
    localparam logic                RST_ENABLE        = 1'b1;
    localparam logic [LEN_W-1:0]    RST_WINDOW_LENGTH = 7'd20;
    localparam logic [WEIGHT_W-1:0] RST_MOTION_WEIGHT = 16'd28547;

    typedef logic [SAMPLE_BITS-1:0] sample_t;

endpackage

// File: hw/rtl/wwrc_serial_div.sv
// ----------------------------------------------------------------------------
// wwrc_serial_div: restoring divider, one quotient bit per cycle
// Latches dividend and divisor on start, pulses done after DIV_W steps and
// holds the quotient until the next start.
// ----------------------------------------------------------------------------
module wwrc_serial_div import wwrc_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DIV_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  dvd_reg, dvd_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [DVS_W:0]    rem_sh;
    logic [DVS_W:0]    diff;
    logic              ge;

    // One trial subtraction per cycle
    always_comb begin
        rem_sh    = {rem_reg, dvd_reg[DIV_W-1]};
        diff      = rem_sh - {1'b0, dvs_reg};
        ge        = rem_sh >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            dvd_next  = {dvd_reg[DIV_W-2:0], ge};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

// File: hw/rtl/wwrc_serial_sqrt.sv
// ----------------------------------------------------------------------------
// wwrc_serial_sqrt: truncating integer square root, one root bit per cycle
// Consumes two radicand bits a step; pulses done after ROOT_W steps and
// holds the root until the next start.
// ----------------------------------------------------------------------------
module wwrc_serial_sqrt import wwrc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int STEP_W = $clog2(ROOT_W);
    localparam int REM_W  = ROOT_W + 2;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic [REM_W+1:0]  diff;
    logic              ge;

    // Trial subtract of 4*root+1 against the shifted remainder
    always_comb begin
        rem_sh    = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial     = (REM_W + 2)'({root_reg, 2'b01});
        diff      = rem_sh - trial;
        ge        = rem_sh >= trial;
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        rad_next  = rad_reg;
        root_next = root_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            rad_next  = radicand;
            root_next = '0;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
            rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
            root_next = {root_reg[ROOT_W-2:0], ge};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(ROOT_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        rad_reg  <= rad_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// File: hw/rtl/windowed_weighted_rms_comfort.sv
// A sample that does not close a window is accepted, then holds s_ready low through the
//   four 4-bit digit steps of the squaring lanes; a disabled sample is dropped in idle.
// A window-closing sample also holds the input through the weight multiply, the mean
//   square divide on the shared bit-serial divider, the root, rounding and the mean
//   divide, until its word is registered; a stalled word delays s_ready.
// Reset (aresetn low, synchronous) clears sums, counters and output valid and
//   restores enable=1, window_length=20, motion_weight=28547.
// ----------------------------------------------------------------------------
// windowed_weighted_rms_comfort: windowed weighted RMS ride-comfort meter
// Accumulates squares of four motion channels; at each window close emits the
// window's comfort value, the running mean and the window count.
// ----------------------------------------------------------------------------
module windowed_weighted_rms_comfort import wwrc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // sample input
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_lateral_accel,
    input  logic signed [SAMPLE_BITS-1:0] s_longitudinal_accel,
    input  logic signed [SAMPLE_BITS-1:0] s_longitudinal_jerk,
    input  logic signed [SAMPLE_BITS-1:0] s_yaw_rate,
    // result output
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [OUT_W-1:0]      m_mean_comfort,
    output logic [OUT_W-1:0]      m_window_comfort,
    output logic [WIN_W-1:0]      m_window_number
);

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_SQUARE   = 4'd1;
    localparam logic [3:0] ST_PREP     = 4'd2;
    localparam logic [3:0] ST_WEIGHT   = 4'd3;
    localparam logic [3:0] ST_MSQ_GO   = 4'd4;
    localparam logic [3:0] ST_MSQ_DIV  = 4'd5;
    localparam logic [3:0] ST_ROOT     = 4'd6;
    localparam logic [3:0] ST_ACCUM    = 4'd7;
    localparam logic [3:0] ST_MEAN_GO  = 4'd8;
    localparam logic [3:0] ST_MEAN_DIV = 4'd9;
    localparam logic [3:0] ST_OUTPUT   = 4'd10;

    localparam int PROD_W  = SAMPLE_BITS + DIG_W;
    localparam int WPROD_W = PAIR_W + DIG_W;
    localparam int DSH_W   = DIGC_W + DIG_LOG;

    // Two's complement magnitude; the most negative code maps to 2^(n-1)
    function automatic sample_t magnitude(input sample_t v);
        magnitude = v[SAMPLE_BITS-1] ? (~v + 1'b1) : v;
    endfunction

    logic [3:0]          state_reg, state_next;
    logic [DIGC_W-1:0]   dig_reg, dig_next;
    logic                enable_reg, enable_next;
    logic [LEN_W-1:0]    wlen_reg, wlen_next;
    logic [WEIGHT_W-1:0] weight_reg, weight_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    sample_t             mag_reg [NLANE];
    sample_t             mag_next [NLANE];
    logic [SUM_W-1:0]    sum_reg [NLANE];
    logic [SUM_W-1:0]    sum_next [NLANE];
    logic [PAIR_W-1:0]   jy_reg, jy_next;
    logic [TOT_W-1:0]    acc_reg, acc_next;
    logic [OUT_W-1:0]    wval_reg, wval_next;
    logic [WIN_W-1:0]    wc_reg, wc_next;
    logic [CT_W-1:0]     total_reg, total_next;
    logic                m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]    m_mean_reg, m_mean_next;
    logic [OUT_W-1:0]    m_wcomf_reg, m_wcomf_next;
    logic [WIN_W-1:0]    m_wnum_reg, m_wnum_next;

    logic [DSH_W-1:0]    dig_sh;
    logic [PROD_W-1:0]   lane_prod [NLANE];
    logic [SUM_W-1:0]    lane_add [NLANE];
    logic [WPROD_W-1:0]  wprod;
    logic [TOT_W-1:0]    acc_add;
    logic [PAIR_W-1:0]   pair_ll;
    logic [CNT_W-1:0]    len_clamp;
    logic [ROOT_W:0]     root_rnd;
    logic [CT_W:0]       total_sum;
    logic [CT_W:0]       mean_dvd;
    logic                out_free;
    logic [CT_W-1:0]     total_upd;
    logic [WIN_W-1:0]    wc_upd;
    logic                upd_en;

    logic                div_start, div_done;
    logic [DIV_W-1:0]    div_dividend, div_quot;
    logic [DVS_W-1:0]    div_divisor;
    logic                sqrt_start, sqrt_done;
    logic [ROOT_W-1:0]   sqrt_root;

    // Window length clamped to 1..MAX_WINDOW
    always_comb begin
        if (wlen_reg == '0) begin
            len_clamp = CNT_W'(1);
        end else if (wlen_reg > MAX_WINDOW) begin
            len_clamp = CNT_W'(MAX_WINDOW);
        end else begin
            len_clamp = CNT_W'(wlen_reg);
        end
    end

    // Digit-serial lanes: each step adds mag * digit, shifted into place
    always_comb begin
        dig_sh = {dig_reg, {DIG_LOG{1'b0}}};
        for (int i = 0; i < NLANE; i++) begin
            lane_prod[i] = mag_reg[i] * mag_reg[i][dig_sh +: DIG_W];
            lane_add[i]  = SUM_W'(lane_prod[i]) << dig_sh;
        end
        wprod   = jy_reg * weight_reg[dig_sh +: DIG_W];
        acc_add = TOT_W'(wprod) << dig_sh;
        pair_ll = {1'b0, sum_reg[0]} + {1'b0, sum_reg[1]};
    end

    // Total and window count update in the cycle after the window value
    always_comb begin
        upd_en    = (state_reg == ST_MEAN_GO);
        total_upd = total_sum[CT_W] ? '1 : total_sum[CT_W-1:0];
        wc_upd    = (&wc_reg) ? wc_reg : wc_reg + 1'b1;
    end

    // Rounding of the root to Q8.8 and the running totals
    always_comb begin
        root_rnd  = {1'b0, sqrt_root} + (ROOT_W + 1)'(1 << (RND_SH - 1));
        total_sum = {1'b0, total_reg} + (CT_W + 1)'(wval_reg);
        mean_dvd  = {1'b0, total_upd} + (CT_W + 1)'(wc_upd >> 1);
    end

    // Shared divider and root unit hookup; the mean divide takes the
    // updated total and count in the same cycle they are registered
    always_comb begin
        div_start  = (state_reg == ST_MSQ_GO) || (state_reg == ST_MEAN_GO);
        sqrt_start = (state_reg == ST_MSQ_DIV) && div_done;
        if (state_reg == ST_MSQ_GO) begin
            div_dividend = acc_reg;
            div_divisor  = DVS_W'(len_clamp);
        end else begin
            div_dividend = DIV_W'(mean_dvd);
            div_divisor  = wc_upd;
        end
    end

    wwrc_serial_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    wwrc_serial_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (RAD_W'(div_quot)),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    // Control sequencer and datapath next state
    always_comb begin
        state_next   = state_reg;
        dig_next     = dig_reg;
        count_next   = count_reg;
        mag_next     = mag_reg;
        sum_next     = sum_reg;
        jy_next      = jy_reg;
        acc_next     = acc_reg;
        wval_next    = wval_reg;
        wc_next      = wc_reg;
        total_next   = total_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_mean_next  = m_mean_reg;
        m_wcomf_next = m_wcomf_reg;
        m_wnum_next  = m_wnum_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && enable_reg) begin
                    mag_next[0] = magnitude(s_lateral_accel);
                    mag_next[1] = magnitude(s_longitudinal_accel);
                    mag_next[2] = magnitude(s_longitudinal_jerk);
                    mag_next[3] = magnitude(s_yaw_rate);
                    count_next  = count_reg + 1'b1;
                    dig_next    = '0;
                    state_next  = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                for (int i = 0; i < NLANE; i++) begin
                    sum_next[i] = sum_reg[i] + lane_add[i];
                end
                dig_next = dig_reg + 1'b1;
                if (dig_reg == DIGC_W'(N_DIG - 1)) begin
                    state_next = (count_reg >= len_clamp) ? ST_PREP : ST_IDLE;
                end
            end
            ST_PREP: begin
                // lat and long squares carry weight one: align to Q16.32
                acc_next   = TOT_W'(pair_ll) << WEIGHT_W;
                jy_next    = {1'b0, sum_reg[2]} + {1'b0, sum_reg[3]};
                for (int i = 0; i < NLANE; i++) begin
                    sum_next[i] = '0;
                end
                count_next = '0;
                dig_next   = '0;
                state_next = ST_WEIGHT;
            end
            ST_WEIGHT: begin
                acc_next = acc_reg + acc_add;
                dig_next = dig_reg + 1'b1;
                if (dig_reg == DIGC_W'(N_DIG - 1)) begin
                    state_next = ST_MSQ_GO;
                end
            end
            ST_MSQ_GO: begin
                state_next = ST_MSQ_DIV;
            end
            ST_MSQ_DIV: begin
                if (div_done) begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (sqrt_done) begin
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM: begin
                // window value saturates, counter sticks at full scale
                if (root_rnd[ROOT_W:RND_SH + OUT_W] != '0) begin
                    wval_next = '1;
                end else begin
                    wval_next = root_rnd[RND_SH +: OUT_W];
                end
                state_next = ST_MEAN_GO;
            end
            ST_MEAN_GO: begin
                // total and count are registered here; divider starts on the new values
                state_next = ST_MEAN_DIV;
            end
            ST_MEAN_DIV: begin
                if (div_done) begin
                    state_next = ST_OUTPUT;
                end
            end
            ST_OUTPUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_wcomf_next = wval_reg;
                    m_wnum_next  = wc_reg;
                    if (div_quot[DIV_W-1:OUT_W] != '0) begin
                        m_mean_next = '1;
                    end else begin
                        m_mean_next = div_quot[OUT_W-1:0];
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration writes
    always_comb begin
        enable_next = enable_reg;
        wlen_next   = wlen_reg;
        weight_next = weight_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_ENABLE:        enable_next = cfg_data[0];
                CFG_WINDOW_LENGTH: wlen_next   = cfg_data[LEN_W-1:0];
                CFG_MOTION_WEIGHT: weight_next = cfg_data[WEIGHT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            dig_reg     <= '0;
            enable_reg  <= RST_ENABLE;
            wlen_reg    <= RST_WINDOW_LENGTH;
            weight_reg  <= RST_MOTION_WEIGHT;
            count_reg   <= '0;
            for (int i = 0; i < NLANE; i++) begin
                sum_reg[i] <= '0;
            end
            wc_reg      <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            dig_reg     <= dig_next;
            enable_reg  <= enable_next;
            wlen_reg    <= wlen_next;
            weight_reg  <= weight_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
            if (upd_en) begin
                wc_reg    <= wc_upd;
                total_reg <= total_upd;
            end else begin
                wc_reg    <= wc_next;
                total_reg <= total_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        mag_reg     <= mag_next;
        jy_reg      <= jy_next;
        acc_reg     <= acc_next;
        wval_reg    <= wval_next;
        m_mean_reg  <= m_mean_next;
        m_wcomf_reg <= m_wcomf_next;
        m_wnum_reg  <= m_wnum_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_mean_comfort   = m_mean_reg;
    assign m_window_comfort = m_wcomf_reg;
    assign m_window_number  = m_wnum_reg;

endmodule

// File: hw/rtl/wwrc_checker.sv
// ----------------------------------------------------------------------------
// wwrc_checker: port-level checks on the comfort meter's result channel
// Watches the result words only; bound to the top level below.
// ----------------------------------------------------------------------------
module wwrc_checker import wwrc_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             m_valid,
    input logic             m_ready,
    input logic [OUT_W-1:0] m_mean_comfort,
    input logic [OUT_W-1:0] m_window_comfort,
    input logic [WIN_W-1:0] m_window_number
);

    logic [WIN_W-1:0] prev_num_reg;
    logic             have_prev_reg;

    // Last delivered window number
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_prev_reg <= 1'b0;
            prev_num_reg  <= '0;
        end else if (m_valid && m_ready) begin
            have_prev_reg <= 1'b1;
            prev_num_reg  <= m_window_number;
        end
    end

    // Stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_mean_comfort)
            && $stable(m_window_comfort) && $stable(m_window_number)))
        else $error("result word changed while stalled");

    // Reset empties the output register
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Windows are numbered from one, each delivered once until the number saturates
    a_first: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !have_prev_reg) |-> (m_window_number == 32'd1))
        else $error("first window not numbered one");

    a_next: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && have_prev_reg) |->
            ((m_window_number == prev_num_reg + 32'd1)
             || ((&prev_num_reg) && (&m_window_number))))
        else $error("window number skipped or repeated");

    // The mean over one window is that window's value
    a_mean1: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_window_number == 32'd1) |-> (m_mean_comfort == m_window_comfort))
        else $error("mean of first window differs from its value");

endmodule

bind windowed_weighted_rms_comfort wwrc_checker u_wwrc_checker (.*);

// File: dv/windowed_weighted_rms_comfort_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_weighted_rms_comfort_tb: self-checking bench for the comfort meter
// Drives motion samples through valid/ready with random gaps and output
// stalls. A local model of the window sums, root and running mean predicts
// each window word, and a checker compares every output word against it.
// ----------------------------------------------------------------------------
module windowed_weighted_rms_comfort_tb;
    import wwrc_pkg::*;

    localparam int RANDOM_SAMPLES = 1450;
    localparam int MAX_GAP        = 18;
    localparam int SETTLE_CYCLES  = 300;     // idle wait after the last queued word
    localparam int MAX_CYCLES     = 2000000;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        sample_t lateral;
        sample_t longitudinal;
        sample_t jerk;
        sample_t yaw;
    } motion_t;

    typedef struct {
        logic [OUT_W-1:0] mean_comfort;
        logic [OUT_W-1:0] window_comfort;
        logic [WIN_W-1:0] window_number;
    } window_word_t;

    // DUT ports; inputs driven from time zero
    logic                  aclk                 = 1'b0;
    logic                  aresetn              = 1'b0;
    logic                  cfg_wr_en            = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index            = CFG_ENABLE;
    logic [CFG_DATA_W-1:0] cfg_data             = '0;
    logic                  s_valid              = 1'b0;
    logic                  s_ready;
    sample_t               s_lateral_accel      = '0;
    sample_t               s_longitudinal_accel = '0;
    sample_t               s_longitudinal_jerk  = '0;
    sample_t               s_yaw_rate           = '0;
    logic                  m_valid;
    logic                  m_ready              = 1'b0;
    logic [OUT_W-1:0]      m_mean_comfort;
    logic [OUT_W-1:0]      m_window_comfort;
    logic [WIN_W-1:0]      m_window_number;

    // Local copy of the block's registers and window state
    logic                cfg_enable     = RST_ENABLE;
    logic [LEN_W-1:0]    cfg_length     = RST_WINDOW_LENGTH;
    logic [WEIGHT_W-1:0] cfg_weight     = RST_MOTION_WEIGHT;
    int unsigned         window_fill    = 0;
    logic [SUM_W-1:0]    lateral_sq     = '0;
    logic [SUM_W-1:0]    longitudinal_sq = '0;
    logic [SUM_W-1:0]    jerk_sq        = '0;
    logic [SUM_W-1:0]    yaw_sq         = '0;
    logic [WIN_W-1:0]    windows_closed = '0;
    logic [CT_W-1:0]     comfort_total  = '0;

    window_word_t pending_windows[$];

    int          mismatches    = 0;
    int          samples_taken = 0;
    int          stall_left    = 0;
    int unsigned cycle_count   = 0;
    bit          gaps_on       = 1'b0;
    bit          stall_on      = 1'b0;

    windowed_weighted_rms_comfort i_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_lateral_accel      (s_lateral_accel),
        .s_longitudinal_accel (s_longitudinal_accel),
        .s_longitudinal_jerk  (s_longitudinal_jerk),
        .s_yaw_rate           (s_yaw_rate),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_mean_comfort       (m_mean_comfort),
        .m_window_comfort     (m_window_comfort),
        .m_window_number      (m_window_number)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= MAX_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Comfort model
    // ------------------------------------------------------------------

    // exact Q16.16 square of a signed Q8.8 sample
    function automatic logic [63:0] square_q88(input sample_t s);
        longint v;
        v = longint'($signed(s));
        return 64'(v * v);
    endfunction

    // truncating square root, one result bit per step
    function automatic logic [31:0] root_floor(input logic [63:0] x);
        logic [31:0] root;
        logic [31:0] trial;
        root = '0;
        for (int i = 31; i >= 0; i--) begin
            trial = root | (32'd1 << i);
            if (64'(trial) * 64'(trial) <= x)
                root = trial;
        end
        return root;
    endfunction

    // fold one accepted sample into the window; queue a word on close
    function automatic void accumulate_sample(input motion_t m);
        int unsigned  len;
        logic [63:0]  weighted;
        logic [63:0]  comfort;
        logic [63:0]  total;
        logic [63:0]  mean;
        logic [63:0]  total_max;
        window_word_t word;
        if (!cfg_enable)
            return;
        // sums of squares wrap at their register width
        lateral_sq      = SUM_W'(64'(lateral_sq) + square_q88(m.lateral));
        longitudinal_sq = SUM_W'(64'(longitudinal_sq) + square_q88(m.longitudinal));
        jerk_sq         = SUM_W'(64'(jerk_sq) + square_q88(m.jerk));
        yaw_sq          = SUM_W'(64'(yaw_sq) + square_q88(m.yaw));
        window_fill++;

        // zero length acts as one, oversize lengths clamp to the max window
        len = cfg_length;
        if (len == 0)
            len = 1;
        if (len > MAX_WINDOW)
            len = MAX_WINDOW;
        if (window_fill < len)
            return;

        weighted = ((64'(lateral_sq) + 64'(longitudinal_sq)) << 16)
                 + 64'(cfg_weight) * (64'(jerk_sq) + 64'(yaw_sq));
        comfort = (64'(root_floor(weighted / 64'(len))) + 64'd128) >> RND_SH;
        if (comfort > 64'hFFFF)
            comfort = 64'hFFFF;

        // window count and total both saturate
        total_max = 64'({CT_W{1'b1}});
        if (windows_closed != '1)
            windows_closed++;
        total = 64'(comfort_total) + comfort;
        if (total > total_max)
            total = total_max;
        comfort_total = total[CT_W-1:0];
        mean = (total + 64'(windows_closed >> 1)) / 64'(windows_closed);
        if (mean > 64'hFFFF)
            mean = 64'hFFFF;

        word.mean_comfort   = mean[OUT_W-1:0];
        word.window_comfort = comfort[OUT_W-1:0];
        word.window_number  = windows_closed;
        pending_windows.push_back(word);

        window_fill     = 0;
        lateral_sq      = '0;
        longitudinal_sq = '0;
        jerk_sq         = '0;
        yaw_sq          = '0;
    endfunction

    // ------------------------------------------------------------------
    // Output side: random stalls and word checking
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready = 1'b0;
            stall_left--;
        end else begin
            m_ready = 1'b1;
        end
    end

    always @(posedge aclk) begin
        window_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_windows.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected word: mean %0d comfort %0d number %0d",
                             m_mean_comfort, m_window_comfort, m_window_number);
            end else begin
                want = pending_windows.pop_front();
                if (m_mean_comfort !== want.mean_comfort ||
                    m_window_comfort !== want.window_comfort ||
                    m_window_number !== want.window_number) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("window %0d mismatch: mean exp %0d got %0d",
                                 want.window_number,
                                 want.mean_comfort, m_mean_comfort);
                        $display("  comfort exp %0d got %0d, number exp %0d got %0d",
                                 want.window_comfort, m_window_comfort,
                                 want.window_number, m_window_number);
                    end
                end
            end
            stall_left = stall_on ? int'($urandom_range(0, MAX_GAP)) : 0;
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // one sample word; returns at the accepting edge
    task automatic send_sample(input motion_t m);
        int gap;
        gap = gaps_on ? int'($urandom_range(0, MAX_GAP)) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid              = 1'b1;
        s_lateral_accel      = m.lateral;
        s_longitudinal_accel = m.longitudinal;
        s_longitudinal_jerk  = m.jerk;
        s_yaw_rate           = m.yaw;
        do
            @(posedge aclk);
        while (!s_ready);
        if (cfg_enable)
            samples_taken++;
        accumulate_sample(m);
    endtask

    // stop sending, wait for every queued word, then let the datapath settle
    task automatic drain_results();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_windows.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            CFG_ENABLE:        cfg_enable = value[0];
            CFG_WINDOW_LENGTH: cfg_length = value[LEN_W-1:0];
            CFG_MOTION_WEIGHT: cfg_weight = value[WEIGHT_W-1:0];
            default: ;
        endcase
    endtask

    function automatic motion_t uniform_motion(input sample_t v);
        motion_t m;
        m.lateral      = v;
        m.longitudinal = v;
        m.jerk         = v;
        m.yaw          = v;
        return m;
    endfunction

    // extremes, small values near zero, or any 16-bit pattern
    function automatic sample_t draw_field();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            3, 4:    return sample_t'(int'($urandom_range(0, 1023)) - 512);
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic motion_t draw_motion();
        motion_t m;
        m.lateral      = draw_field();
        m.longitudinal = draw_field();
        m.jerk         = draw_field();
        m.yaw          = draw_field();
        return m;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // reset config: window of 20, default weight; corner values rotated
    task automatic test_default_window();
        sample_t corner[5];
        motion_t m;
        corner = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
        for (int i = 0; i < 20; i++) begin
            m.lateral      = corner[i % 5];
            m.longitudinal = corner[(i + 1) % 5];
            m.jerk         = corner[(i + 2) % 5];
            m.yaw          = corner[(i + 3) % 5];
            send_sample(m);
        end
        drain_results();
    endtask

    // full weight saturates the comfort value; zero weight drops jerk/yaw
    task automatic test_weight_extremes();
        motion_t m;
        write_reg(CFG_WINDOW_LENGTH, CFG_DATA_W'(1));
        write_reg(CFG_MOTION_WEIGHT, '1);
        send_sample(uniform_motion(16'h8000));
        send_sample(uniform_motion(16'h7FFF));
        drain_results();
        write_reg(CFG_MOTION_WEIGHT, '0);
        m.lateral      = 16'h0001;
        m.longitudinal = 16'hFFFF;
        m.jerk         = 16'h7FFF;
        m.yaw          = 16'h8000;
        send_sample(m);
        drain_results();
    endtask

    // zero window length behaves as one sample per window
    task automatic test_zero_length();
        write_reg(CFG_MOTION_WEIGHT, CFG_DATA_W'(RST_MOTION_WEIGHT));
        write_reg(CFG_WINDOW_LENGTH, '0);
        send_sample(draw_motion());
        send_sample(draw_motion());
        drain_results();
    endtask

    // length cut below the current fill closes on the next sample
    task automatic test_length_lowered();
        write_reg(CFG_WINDOW_LENGTH, CFG_DATA_W'(MAX_WINDOW));
        send_sample(draw_motion());
        send_sample(draw_motion());
        drain_results();
        write_reg(CFG_WINDOW_LENGTH, CFG_DATA_W'(1));
        send_sample(draw_motion());
        drain_results();
    endtask

    // disabled: samples dropped and state held
    task automatic test_disabled();
        write_reg(CFG_WINDOW_LENGTH, CFG_DATA_W'(2));
        send_sample(draw_motion());
        drain_results();
        write_reg(CFG_ENABLE, '0);
        send_sample(uniform_motion(16'h7FFF));
        send_sample(uniform_motion(16'h8000));
        drain_results();
        write_reg(CFG_ENABLE, CFG_DATA_W'(1));
        send_sample(draw_motion());
        drain_results();
    endtask

    // sender holds off while a window word is still in flight
    task automatic test_sender_pause();
        gaps_on  = 1'b1;
        stall_on = 1'b1;
        send_sample(draw_motion());
        send_sample(draw_motion());
        drain_results();
        send_sample(draw_motion());
        send_sample(draw_motion());
        drain_results();
    endtask

    // random phases: config, idle pattern and sample mix all drawn per phase
    task automatic test_random();
        int          goal;
        int          phase_items;
        int          pause_at;
        int unsigned pick;
        logic [CFG_DATA_W-1:0] len;
        logic [CFG_DATA_W-1:0] weight;
        bit          first_phase;
        goal        = samples_taken + RANDOM_SAMPLES;
        first_phase = 1'b1;
        while (samples_taken < goal) begin
            drain_results();
            pick = $urandom_range(0, 19);
            case (pick)
                0:       len = '0;
                1:       len = CFG_DATA_W'(MAX_WINDOW);
                2:       len = CFG_DATA_W'(127);
                3:       len = CFG_DATA_W'($urandom_range(MAX_WINDOW + 1, 126));
                4, 5, 6: len = CFG_DATA_W'($urandom_range(9, MAX_WINDOW - 1));
                default: len = CFG_DATA_W'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 5))
                0:       weight = '0;
                1:       weight = '1;
                2:       weight = CFG_DATA_W'(RST_MOTION_WEIGHT);
                default: weight = CFG_DATA_W'($urandom);
            endcase
            write_reg(CFG_WINDOW_LENGTH, len);
            write_reg(CFG_MOTION_WEIGHT, weight);
            write_reg(CFG_ENABLE, ($urandom_range(0, 9) == 0) ? '0 : CFG_DATA_W'(1));
            gaps_on  = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);

            phase_items = $urandom_range(4, 60);
            pause_at    = (first_phase || $urandom_range(0, 3) == 0)
                        ? int'($urandom_range(1, phase_items - 1)) : -1;
            first_phase = 1'b0;
            for (int i = 0; i < phase_items; i++) begin
                if (i == pause_at)
                    drain_results();
                send_sample(draw_motion());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_default_window();
        test_weight_extremes();
        test_zero_length();
        test_length_lowered();
        test_disabled();
        test_sender_pause();
        test_random();

        drain_results();
        if (mismatches == 0 && pending_windows.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches, %0d words missing", mismatches,
                     pending_windows.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
